FILE: rtl/lrt_pkg.sv
package lrt_pkg;

  // default geometry of the table and of one block
  localparam int MAP_ENTRIES_DEF = 4096;
  localparam int BLOCK_BYTES_DEF = 4096;

  // fixed field widths
  localparam int OFFSET_W  = 63;
  localparam int SIZE_W    = 49;
  localparam int DEV_OFF_W = 48;
  localparam int SKIP_W    = 32;
  localparam int DIV_CNT_W = $clog2(OFFSET_W);

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 64;
  localparam logic REG_REMAP = 1'b0;
  localparam logic REG_SIZE  = 1'b1;

  // largest usable device size, 2^48 bytes
  localparam logic [SIZE_W-1:0] SIZE_CAP = {1'b1, {(SIZE_W-1){1'b0}}};

  // multiplicative hash constant
  localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

  typedef enum logic [1:0] {
    OUT_PASS = 2'd0,
    OUT_HIT  = 2'd1,
    OUT_NEW  = 2'd2,
    OUT_SKIP = 2'd3
  } outcome_t;

endpackage

FILE: rtl/lrt_ram.sv
module lrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/lba_remap_table.sv
// Block write remapper. Each transaction on the input carries the byte offset
// of one block write; each yields one result transaction. With remap_enable
// clear the result is the offset modulo the device size (capped at 2^48),
// rounded down to a block boundary; a radix-2 remainder unit retires one
// dividend bit per cycle over all 63 offset bits, and the result is then
// registered; the next input is taken only once that result has been loaded.
// With remap_enable set the block LBA is hashed with one shared 32x32
// multiplier, then the table memory is probed linearly, each probed slot with
// a registered read and then a compare, and the next input is taken only once
// the result has been loaded. While an earlier result waits on out_ready the
// sequencer holds in its last step. A miss takes the next sequential device
// LBA unless that counter has reached the device block count or the table
// size, in which case the write is skipped, counted and answered with offset
// zero. After reset the table is cleared one entry a cycle, during which
// in_ready stays low; register writes are taken at any time. MAP_ENTRIES and
// BLOCK_BYTES must be powers of two. Registers: remap_enable at byte
// address 0, dev_size at byte address 8.
module lba_remap_table
  import lrt_pkg::*;
#(
  parameter int MAP_ENTRIES = MAP_ENTRIES_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ADDR_W-1:0]                paddr,
  input  logic [DATA_W-1:0]                pwdata,
  output logic [DATA_W-1:0]                prdata,
  output logic                             pready,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [OFFSET_W-1:0]              wr_offset,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [DEV_OFF_W-1:0]             dev_offset,
  output logic [1:0]                       outcome,
  output logic [$clog2(MAP_ENTRIES):0]     unique_count,
  output logic [SKIP_W-1:0]                skipped_count
);

  localparam int IDX_W    = $clog2(MAP_ENTRIES);
  localparam int CNT_W    = IDX_W + 1;
  localparam int BB_SHIFT = $clog2(BLOCK_BYTES);
  localparam int KEY_W    = OFFSET_W - BB_SHIFT;
  localparam int ENT_W    = 1 + KEY_W + IDX_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_PASS_OUT,
    S_HASH,
    S_READ,
    S_CMP
  } state_t;

  state_t                 state;
  logic                   remap_enable;
  logic [SIZE_W-1:0]      dev_size;
  logic [OFFSET_W-1:0]    off_q;
  logic [DEV_OFF_W-1:0]   rem;
  logic [DIV_CNT_W-1:0]   dcnt;
  logic [1:0]             hstep;
  logic [63:0]            prod;
  logic [63:0]            acc;
  logic [IDX_W-1:0]       slot;
  logic [CNT_W-1:0]       probes;
  logic [IDX_W-1:0]       clr_addr;
  logic [CNT_W-1:0]       next_lba;
  logic [SKIP_W-1:0]      skip_counter;

  logic [SIZE_W-1:0]      eff_size;
  logic                   lim_reached;
  logic [KEY_W-1:0]       key;
  logic [63:0]            hash_x;
  logic [31:0]            mul_a;
  logic [31:0]            mul_b;
  logic [63:0]            hash_sum;
  logic [SIZE_W-1:0]      rem_trial;
  logic [SIZE_W-1:0]      rem_sub;
  logic                   rem_ge;
  logic                   out_free;
  logic                   res_load;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [ENT_W-1:0]       ram_wdata;
  logic                   ram_re;
  logic [ENT_W-1:0]       ram_rdata;
  logic                   ent_valid;
  logic [KEY_W-1:0]       ent_key;
  logic [IDX_W-1:0]       ent_lba;
  logic                   ent_hit;
  logic                   probe_last;
  logic                   do_new;

  function automatic logic [DEV_OFF_W-1:0] lba_offset(input logic [CNT_W-1:0] lba);
    logic [63:0] wide;
    wide = {{(64-CNT_W){1'b0}}, lba} << BB_SHIFT;
    return wide[DEV_OFF_W-1:0];
  endfunction

  // configuration registers
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_SIZE)
                  ? {{(DATA_W-SIZE_W){1'b0}}, dev_size}
                  : {{(DATA_W-1){1'b0}}, remap_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      remap_enable <= 1'b0;
      dev_size     <= SIZE_W'(BLOCK_BYTES_DEF);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[ADDR_W-1] == REG_REMAP) begin
        remap_enable <= pwdata[0];
      end else begin
        dev_size <= pwdata[SIZE_W-1:0];
      end
    end
  end

  // device size capped at 2^48, and the allocation limit
  assign eff_size    = (dev_size > SIZE_CAP) ? SIZE_CAP : dev_size;
  assign lim_reached = (next_lba >= CNT_W'(MAP_ENTRIES))
                    || ({{(SIZE_W-CNT_W){1'b0}}, next_lba} >= (eff_size >> BB_SHIFT));

  // remainder step: shift in one dividend bit, subtract when it fits
  assign rem_trial = {rem, off_q[OFFSET_W-1]};
  assign rem_ge    = rem_trial >= eff_size;
  assign rem_sub   = rem_trial - eff_size;

  // hash: low 64 bits of x * HASH_MULT from three 32x32 partial products
  assign key    = off_q[OFFSET_W-1:BB_SHIFT];
  assign hash_x = {{(64-KEY_W){1'b0}}, key ^ (key >> 29)};

  always_comb begin
    case (hstep)
      2'd0: begin
        mul_a = hash_x[31:0];
        mul_b = HASH_MULT[31:0];
      end
      2'd1: begin
        mul_a = hash_x[63:32];
        mul_b = HASH_MULT[31:0];
      end
      default: begin
        mul_a = hash_x[31:0];
        mul_b = HASH_MULT[63:32];
      end
    endcase
  end

  assign hash_sum = acc + {prod[31:0], 32'd0};

  // table entry fields and probe decision
  assign ent_valid  = ram_rdata[ENT_W-1];
  assign ent_key    = ram_rdata[IDX_W +: KEY_W];
  assign ent_lba    = ram_rdata[IDX_W-1:0];
  assign ent_hit    = ent_valid && (ent_key == key);
  assign probe_last = !ent_valid || ent_hit || (probes == CNT_W'(MAP_ENTRIES - 1));
  assign do_new     = !ent_valid && !lim_reached;

  // memory ports: clearing pass or new mapping on write, probe on read
  assign ram_re    = (state == S_READ);
  assign ram_we    = (state == S_CLEAR) || ((state == S_CMP) && out_free && do_new);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : slot;
  assign ram_wdata = (state == S_CLEAR) ? '0 : {1'b1, key, next_lba[IDX_W-1:0]};

  lrt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAP_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // result register loads on the last step of an item
  assign res_load = out_free && ((state == S_PASS_OUT) || ((state == S_CMP) && probe_last));

  // sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      next_lba     <= '0;
      skip_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_W'(MAP_ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            off_q <= wr_offset;
            rem   <= '0;
            dcnt  <= '0;
            hstep <= '0;
            state <= remap_enable ? S_HASH : S_DIV;
          end
        end
        S_DIV: begin
          rem   <= rem_ge ? rem_sub[DEV_OFF_W-1:0] : rem_trial[DEV_OFF_W-1:0];
          off_q <= off_q << 1;
          dcnt  <= dcnt + 1'b1;
          if (dcnt == DIV_CNT_W'(OFFSET_W - 1)) begin
            state <= S_PASS_OUT;
          end
        end
        S_PASS_OUT: begin
          if (out_free) begin
            dev_offset    <= (eff_size == '0) ? '0
                             : {rem[DEV_OFF_W-1:BB_SHIFT], {BB_SHIFT{1'b0}}};
            outcome       <= OUT_PASS;
            unique_count  <= next_lba;
            skipped_count <= skip_counter;
            state         <= S_IDLE;
          end
        end
        S_HASH: begin
          prod  <= 64'(mul_a) * 64'(mul_b);
          hstep <= hstep + 1'b1;
          if (hstep == 2'd1) begin
            acc <= prod;
          end else if (hstep == 2'd2) begin
            acc <= hash_sum;
          end else if (hstep == 2'd3) begin
            slot   <= hash_sum[32 +: IDX_W];
            probes <= '0;
            state  <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (!probe_last) begin
            slot   <= slot + 1'b1;
            probes <= probes + 1'b1;
            state  <= S_READ;
          end else if (out_free) begin
            state <= S_IDLE;
            if (ent_hit) begin
              dev_offset    <= lba_offset({1'b0, ent_lba});
              outcome       <= OUT_HIT;
              unique_count  <= next_lba;
              skipped_count <= skip_counter;
            end else if (do_new) begin
              dev_offset    <= lba_offset(next_lba);
              outcome       <= OUT_NEW;
              next_lba      <= next_lba + 1'b1;
              unique_count  <= next_lba + 1'b1;
              skipped_count <= skip_counter;
            end else begin
              dev_offset    <= '0;
              outcome       <= OUT_SKIP;
              unique_count  <= next_lba;
              if (skip_counter != '1) begin
                skip_counter  <= skip_counter + 1'b1;
                skipped_count <= skip_counter + 1'b1;
              end else begin
                skipped_count <= skip_counter;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // no result leaves while the table is being cleared
  assert property (@(posedge clk) disable iff (rst) (state == S_CLEAR) |-> !out_valid)
    else $error("result valid during clearing pass");

  // device lba counter never passes the table size
  assert property (@(posedge clk) disable iff (rst) next_lba <= CNT_W'(MAP_ENTRIES))
    else $error("next_lba beyond table size");

  // a new mapping written to the table advances the lba counter by one
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_CMP) && ram_we) |=> (next_lba == $past(next_lba) + 1'b1))
    else $error("new mapping without counter advance");

  // skip counter never goes down
  assert property (@(posedge clk) disable iff (rst) 1'b1 |=> skip_counter >= $past(skip_counter))
    else $error("skip counter decreased");
`endif

endmodule
